// ===== design/crc_pkg.sv =====
// Shared types and constants for the Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package crc_pkg;

  localparam int unsigned MaxPointsDef = 6;
  localparam int unsigned CntW = 3;          // point count register
  localparam int unsigned XW   = 16;         // x, unsigned Q1.15
  localparam int unsigned YW   = 16;         // y, signed Q4.11
  localparam int unsigned PtW  = 32;         // packed control point
  localparam int unsigned TW   = 17;         // t, unsigned Q1.16 in [0, 1]
  localparam int unsigned AW   = YW + 1;     // coefficient a
  localparam int unsigned CW   = YW + 4;     // coefficients b and c
  localparam int unsigned HW   = 24;         // Horner accumulator
  localparam int unsigned PW   = HW + TW + 1;// Horner product

  localparam int unsigned RegPointCount = 0; // registers 1..N are the points

  typedef struct packed {
    logic                 special;  // fewer than two points
    logic signed [YW-1:0] y_sp;     // result for the special case
    logic signed [AW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [YW-1:0] p1;
  } coef_t;

endpackage
`default_nettype wire

// ===== design/crc_seg.sv =====
// Segment search, clamp and cubic coefficient setup (two register stages).
`timescale 1ns / 1ps
`default_nettype none
module crc_seg #(
  parameter int unsigned MaxPoints = crc_pkg::MaxPointsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [crc_pkg::XW-1:0]    x_i,
  input  wire logic [crc_pkg::CntW-1:0]  count_i,
  input  wire logic [crc_pkg::PtW-1:0]   points_i [MaxPoints],
  output logic                           valid_o,
  output logic [crc_pkg::XW-1:0]         num_o,
  output logic [crc_pkg::XW-1:0]         span_o,
  output crc_pkg::coef_t                 coef_o
);
  import crc_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPoints);

  // stage A: clamp and search
  logic [CntW-1:0] n;
  logic [XW-1:0]   lo, hi, xc;
  logic [IdxW-1:0] seg_i;
  logic            go;

  logic            va_q;
  logic [XW-1:0]   xc_q;
  logic [IdxW-1:0] i_q;
  logic [CntW-1:0] n_q;

  always_comb begin
    n = (count_i > CntW'(MaxPoints)) ? CntW'(MaxPoints) : count_i;
    lo = points_i[0][PtW-1:YW];
    hi = lo;
    for (int k = 0; k < MaxPoints; k++) begin
      if (CntW'(k + 1) == n) hi = points_i[k][PtW-1:YW];
    end
    if (x_i < lo) xc = lo;
    else if (x_i > hi) xc = hi;
    else xc = x_i;
    seg_i = '0;
    go = 1'b1;
    for (int k = 1; k < MaxPoints - 1; k++) begin
      if (go && (CntW'(k + 1) < n) && (xc > points_i[k][PtW-1:YW])) begin
        seg_i = IdxW'(k);
      end else begin
        go = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xc_q <= xc;
      i_q  <= seg_i;
      n_q  <= n;
    end
  end

  // stage B: pick points, span and coefficients
  logic [XW-1:0]        x1, x2;
  logic signed [YW-1:0] p0, p1, p2, p3, y0;
  logic signed [XW:0]   span_s, num_s;
  logic [XW-1:0]        num_d, span_d;
  logic signed [CW-1:0] e0, e1, e2, e3;
  coef_t                coef_d;

  always_comb begin
    x1 = '0; x2 = '0; p1 = '0; p2 = '0; p0 = '0; p3 = '0;
    for (int k = 0; k < MaxPoints; k++) begin
      if (int'(i_q) == k) begin
        x1 = points_i[k][PtW-1:YW];
        p1 = $signed(points_i[k][YW-1:0]);
      end
      if (int'(i_q) + 1 == k) begin
        x2 = points_i[k][PtW-1:YW];
        p2 = $signed(points_i[k][YW-1:0]);
      end
    end
    p0 = p1;
    p3 = p2;
    for (int k = 0; k < MaxPoints; k++) begin
      if (int'(i_q) == k + 1) p0 = $signed(points_i[k][YW-1:0]);
      if ((int'(i_q) + 2 == k) && (int'(i_q) + 2 < int'(n_q))) begin
        p3 = $signed(points_i[k][YW-1:0]);
      end
    end
    y0 = $signed(points_i[0][YW-1:0]);

    span_s = $signed({1'b0, x2}) - $signed({1'b0, x1});
    num_s  = $signed({1'b0, xc_q}) - $signed({1'b0, x1});
    if (span_s > 0) begin
      span_d = span_s[XW-1:0];
      if (num_s < 0) num_d = '0;
      else if (num_s > span_s) num_d = span_s[XW-1:0];
      else num_d = num_s[XW-1:0];
    end else begin
      // zero or negative span: force t to zero
      span_d = XW'(1);
      num_d  = '0;
    end

    e0 = CW'(p0);
    e1 = CW'(p1);
    e2 = CW'(p2);
    e3 = CW'(p3);
    coef_d.special = (n_q < CntW'(2));
    coef_d.y_sp    = (n_q == '0) ? '0 : y0;
    coef_d.a       = AW'(p2) - AW'(p0);
    coef_d.b       = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    coef_d.c       = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
    coef_d.p1      = p1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_d;
      span_o <= span_d;
      coef_o <= coef_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/crc_div.sv =====
// Pipelined restoring divider for t = (num << 16) / span, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module crc_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [crc_pkg::XW-1:0] num_i,
  input  wire logic [crc_pkg::XW-1:0] span_i,
  input  wire crc_pkg::coef_t         coef_i,
  output logic                        valid_o,
  output logic [crc_pkg::TW-1:0]      t_o,
  output crc_pkg::coef_t              coef_o
);
  import crc_pkg::*;

  logic          v_q [TW];
  logic [XW:0]   r_q [TW];
  logic [TW-1:0] q_q [TW];
  logic [XW-1:0] d_q [TW];
  coef_t         c_q [TW];

  for (genvar s = 0; s < TW; s++) begin : g_stage
    logic          v_in, ge;
    logic [XW:0]   r_in, r_out;
    logic [TW-1:0] q_in;
    logic [XW-1:0] d_in;
    coef_t         c_in;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = {1'b0, num_i};
      assign q_in = '0;
      assign d_in = span_i;
      assign c_in = coef_i;
    end else begin : g_next
      // remainder stays below the divisor, so the shift never overflows
      assign v_in = v_q[s-1];
      assign r_in = {r_q[s-1][XW-1:0], 1'b0};
      assign q_in = q_q[s-1];
      assign d_in = d_q[s-1];
      assign c_in = c_q[s-1];
    end

    assign ge    = (r_in >= {1'b0, d_in});
    assign r_out = ge ? (r_in - {1'b0, d_in}) : r_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_out;
        q_q[s] <= {q_in[TW-2:0], ge};
        d_q[s] <= d_in;
        c_q[s] <= c_in;
      end
    end
  end

  assign valid_o = v_q[TW-1];
  assign t_o     = q_q[TW-1];
  assign coef_o  = c_q[TW-1];

endmodule
`default_nettype wire

// ===== design/crc_hrn.sv =====
// Horner evaluation of the cubic: multiply and round-add stages, then saturate or pick the special-case result.
`timescale 1ns / 1ps
`default_nettype none
module crc_hrn (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [crc_pkg::TW-1:0] t_i,
  input  wire crc_pkg::coef_t         coef_i,
  output logic                        valid_o,
  output logic signed [crc_pkg::YW-1:0] y_o
);
  import crc_pkg::*;

  localparam int unsigned Steps = 3;

  logic                 vm_q [Steps];
  logic                 va_q [Steps];
  logic signed [PW-1:0] pr_q [Steps];
  logic signed [HW-1:0] h_q  [Steps];
  coef_t                cm_q [Steps];
  coef_t                ca_q [Steps];
  logic [TW-1:0]        tm_q [Steps];
  logic [TW-1:0]        ta_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic                 v_in;
    logic signed [HW-1:0] h_in, addend;
    logic [TW-1:0]        t_in;
    coef_t                c_in;
    logic signed [PW-1:0] prod, rnd;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign h_in = HW'(coef_i.c);
      assign t_in = t_i;
      assign c_in = coef_i;
    end else begin : g_next
      assign v_in = va_q[s-1];
      assign h_in = h_q[s-1];
      assign t_in = ta_q[s-1];
      assign c_in = ca_q[s-1];
    end

    if (s == 0) begin : g_add_b
      assign addend = HW'(cm_q[s].b);
    end else if (s == 1) begin : g_add_a
      assign addend = HW'(cm_q[s].a);
    end else begin : g_add_p1
      assign addend = HW'(cm_q[s].p1) <<< 1;
    end

    assign prod = PW'(h_in) * $signed({{(PW-TW){1'b0}}, t_in});
    // round half up, then floor shift by 16
    assign rnd  = pr_q[s] + (PW'(1) <<< 15);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q[s] <= 1'b0;
        va_q[s] <= 1'b0;
      end else if (en_i) begin
        vm_q[s] <= v_in;
        va_q[s] <= vm_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q[s] <= prod;
        cm_q[s] <= c_in;
        tm_q[s] <= t_in;
        h_q[s]  <= rnd[HW+15:16] + addend;
        ca_q[s] <= cm_q[s];
        ta_q[s] <= tm_q[s];
      end
    end
  end

  logic signed [HW-1:0] hr;

  always_comb begin
    hr = (h_q[Steps-1] + HW'(1)) >>> 1;
    if (ca_q[Steps-1].special) y_o = ca_q[Steps-1].y_sp;
    else if (hr > HW'(32767)) y_o = 16'sh7fff;
    else if (hr < -HW'(32768)) y_o = 16'sh8000;
    else y_o = hr[YW-1:0];
  end

  assign valid_o = va_q[Steps-1];

endmodule
`default_nettype wire

// ===== design/catmull_rom_curve_evaluate.sv =====
// Top level of the pipelined Catmull-Rom curve evaluator.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_ready_o     x_in_i
//   out      output     out_valid_o / out_ready_i   y_out_o
//   cfg      input      cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// One request enters per cycle while the output is not stalled; each passes 2 setup stages,
// 17 divider stages, one per quotient bit, and 6 Horner multiply/add stages.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears the point registers, the count and every valid bit.
// A stall on the output holds every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_curve_evaluate #(
  parameter int unsigned MAX_POINTS = crc_pkg::MaxPointsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0] cfg_idx_i,
  input  wire logic [crc_pkg::PtW-1:0]       cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [crc_pkg::XW-1:0]        x_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [crc_pkg::YW-1:0]      y_out_o
);
  import crc_pkg::*;

  localparam int unsigned CfgIdxW = $clog2(MAX_POINTS + 1);

  logic [CntW-1:0] count_q;
  logic [PtW-1:0]  point_q [MAX_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < MAX_POINTS; k++) point_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxW'(RegPointCount)) begin
        count_q <= cfg_data_i[CntW-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_idx_i == CfgIdxW'(k + 1)) point_q[k] <= cfg_data_i;
      end
    end
  end

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic          seg_valid, div_valid;
  logic [XW-1:0] seg_num, seg_span;
  logic [TW-1:0] div_t;
  coef_t         seg_coef, div_coef;

  crc_seg #(.MaxPoints(MAX_POINTS)) u_seg (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .x_i(x_in_i),
    .count_i(count_q), .points_i(point_q),
    .valid_o(seg_valid), .num_o(seg_num), .span_o(seg_span), .coef_o(seg_coef)
  );

  crc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(seg_valid), .num_i(seg_num),
    .span_i(seg_span), .coef_i(seg_coef),
    .valid_o(div_valid), .t_o(div_t), .coef_o(div_coef)
  );

  crc_hrn u_hrn (
    .clk_i, .rst_ni, .en_i(en), .valid_i(div_valid), .t_i(div_t),
    .coef_i(div_coef), .valid_o(out_valid_o), .y_o(y_out_o)
  );

  // t never exceeds one
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && div_t[TW-1] |-> div_t[TW-2:0] == '0)
    else $error("t above one");

  // a stall freezes the pipeline valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(seg_valid) && $stable(div_valid) && $stable(out_valid_o))
    else $error("pipeline moved during stall");

  // a stalled item in the last divider stage is not lost
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && !en |=> div_valid && $stable(div_t))
    else $error("divider result lost in stall");

endmodule
`default_nettype wire

// ===== verif/tb_catmull_rom_curve_evaluate.sv =====
// Testbench for the Catmull-Rom curve evaluator: directed and randomized requests checked against a predictor.
`timescale 1ns / 1ps
module tb_catmull_rom_curve_evaluate;
  import crc_pkg::*;

  localparam int unsigned NPts    = MaxPointsDef;
  localparam int unsigned IdxW    = $clog2(NPts + 1);
  localparam int unsigned Latency = 25;
  localparam int unsigned IdxPastList = NPts + 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [IdxW-1:0]       cfg_idx_i = '0;
  logic [PtW-1:0]        cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [XW-1:0]         x_in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [YW-1:0]  y_out_o;

  catmull_rom_curve_evaluate u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .x_in_i, .out_valid_o, .out_ready_i, .y_out_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the curve registers
  logic [CntW-1:0] curve_cnt = '0;
  logic [PtW-1:0]  curve_pts [NPts];

  logic [XW-1:0]        x_pending [$];
  logic signed [YW-1:0] y_expected [$];
  int unsigned mismatch_cnt = 0;
  int unsigned accepted_cnt = 0;
  bit          accept_seen = 1'b0;
  bit          hold_done = 1'b0;

  function automatic longint round_off(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint knot_x(int k);
    return longint'(curve_pts[k][31:16]);
  endfunction

  function automatic longint knot_y(int k);
    return longint'($signed(curve_pts[k][15:0]));
  endfunction

  function automatic logic signed [YW-1:0] curve_value(logic [XW-1:0] xq);
    int     n, i;
    longint x, lo, hi, x1, x2, span, num, t, p0, p1, p2, p3, a, b, c, h, y;
    n = (curve_cnt > NPts) ? NPts : curve_cnt;
    x = longint'(xq);
    if (n == 0) begin
      y = 0;
    end else if (n == 1) begin
      y = knot_y(0);
    end else begin
      lo = knot_x(0);
      hi = knot_x(n - 1);
      if (x < lo) x = lo;
      else if (x > hi) x = hi;
      i = 0;
      while (i + 2 < n && x > knot_x(i + 1)) i++;
      x1 = knot_x(i);
      x2 = knot_x(i + 1);
      span = x2 - x1;
      if (span > 0) begin
        num = x - x1;
        if (num < 0) num = 0;
        if (num > span) num = span;
        t = (num <<< 16) / span;
      end else begin
        t = 0;
      end
      p1 = knot_y(i);
      p2 = knot_y(i + 1);
      p0 = (i > 0) ? knot_y(i - 1) : p1;
      p3 = (i + 2 < n) ? knot_y(i + 2) : p2;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + 3 * p1 - 3 * p2 + p3;
      h = c;
      h = round_off(h * t, 16) + b;
      h = round_off(h * t, 16) + a;
      h = round_off(h * t, 16) + 2 * p1;
      y = round_off(h, 1);
    end
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[YW-1:0];
  endfunction

  // Record accepted requests and check results
  always @(posedge clk_i) begin
    accept_seen = in_valid_i && in_ready_o;
    if (accept_seen) begin
      y_expected.insert(y_expected.size(), curve_value(x_in_i));
      accepted_cnt++;
    end
    if (out_valid_o && out_ready_i) begin
      if (y_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result y=%0d", y_out_o);
      end else begin
        if (y_out_o !== y_expected[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("y mismatch: expected %0d, got %0d", y_expected[0], y_out_o);
        end
        void'(y_expected.pop_front());
      end
    end
  end

  // Request driver: bursts with random gaps
  int unsigned burst_left = 1, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || accept_seen)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (x_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        x_in_i     <= x_pending.pop_front();
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall pattern, one long hold-off
  int unsigned stall_pct = 0, mode_left = 0, hold_left = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 70;
      endcase
    end
    mode_left--;
    if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_reg(int unsigned idx, logic [PtW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[IdxW-1:0];
    cfg_data_i <= data;
    if (idx == RegPointCount) curve_cnt = data[CntW-1:0];
    else if (idx <= NPts) curve_pts[idx - 1] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (x_pending.size() > 0 || in_valid_i || y_expected.size() > 0) @(posedge clk_i);
    repeat (Latency + 15) @(posedge clk_i);
  endtask

  // Random curve: mostly sorted x, sometimes shuffled or with repeated x
  task automatic load_curve(int unsigned cnt);
    logic [XW-1:0] xs [NPts];
    int unsigned   shape;
    shape = $urandom_range(0, 9);
    foreach (xs[k]) xs[k] = XW'($urandom);
    if (shape < 7) xs.sort();
    if (shape == 9) begin
      xs.sort();
      xs[2] = xs[1];
      xs[3] = xs[1];
    end
    for (int k = 0; k < NPts; k++) write_reg(k + 1, {xs[k], 16'($urandom)});
    write_reg(RegPointCount, cnt);
  endtask

  initial begin
    foreach (curve_pts[k]) curve_pts[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty curve straight out of reset
    x_pending = '{16'h0000, 16'hFFFF};
    drain();
    // single point
    write_reg(1, {16'h1234, 16'h8000});
    write_reg(RegPointCount, 1);
    x_pending = '{16'h0000, 16'hFFFF};
    drain();
    // full-range curve with extreme y, drives saturation
    write_reg(1, {16'h0000, 16'h7FFF});
    write_reg(2, {16'h2000, 16'h8000});
    write_reg(3, {16'h5000, 16'h7FFF});
    write_reg(4, {16'h9000, 16'h8000});
    write_reg(5, {16'hC000, 16'h7FFF});
    write_reg(6, {16'hFFFF, 16'h8000});
    write_reg(RegPointCount, 6);
    x_pending = '{16'h0000, 16'h1000, 16'h2000, 16'h3800, 16'h7000,
                  16'hA800, 16'hE000, 16'hFFFF};
    drain();
    // count above capacity; index past the list is ignored
    write_reg(RegPointCount, 7);
    write_reg(IdxPastList, 32'hFFFF_FFFF);
    x_pending = '{16'h4000, 16'hF000};
    drain();
    // unsorted points and a zero span, queries outside the range
    write_reg(1, {16'h8000, 16'h0800});
    write_reg(2, {16'h4000, 16'hF800});
    write_reg(3, {16'h4000, 16'h1000});
    write_reg(4, {16'hC000, 16'h0000});
    write_reg(RegPointCount, 4);
    x_pending = '{16'h0000, 16'h4000, 16'h6000, 16'hA000, 16'hFFFF};
    drain();

    for (int p = 0; p < 10; p++) begin
      load_curve((p < 2) ? p : $urandom_range(2, 7));
      repeat (($urandom_range(0, 3) == 0) ? 0 : 152) @(posedge clk_i);
      for (int k = 0; k < 152; k++) x_pending.insert(x_pending.size(), XW'($urandom));
      drain();
    end

    if (y_expected.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("catmull_rom_curve_evaluate: match");
    end else begin
      $display("catmull_rom_curve_evaluate: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("catmull_rom_curve_evaluate: mismatch");
    $finish;
  end

endmodule
